FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the scan code translator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in a cycle implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in a cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sctr_pkg.sv
// Package: types, key codes and translation tables of the scan code translator.
`default_nettype none
package sctr_pkg;

    localparam logic [6:0] KEY_C     = 7'h2E;
    localparam logic [6:0] KEY_D     = 7'h20;
    localparam logic [6:0] KEY_LSH   = 7'h2A;
    localparam logic [6:0] KEY_RSH   = 7'h36;
    localparam logic [6:0] KEY_CTRL  = 7'h1D;
    localparam logic [6:0] KEY_CAPS  = 7'h3A;
    localparam logic [6:0] KEY_TAB   = 7'h0F;
    localparam logic [6:0] KEY_BKSP  = 7'd14;
    localparam logic [6:0] KEY_ENTER = 7'd28;
    localparam logic [6:0] KEY_ESC   = 7'h01;
    localparam logic [6:0] KEY_NONE  = 7'h00;
    localparam logic [6:0] KEY_LEFT  = 7'd75;
    localparam logic [6:0] KEY_RIGHT = 7'd77;

    localparam logic [7:0] CASE_DIFF  = 8'd32;
    localparam logic [2:0] TAB_SPACES = 3'd5;

    localparam logic [7:0] ASC_BKSP  = 8'h01;
    localparam logic [7:0] ASC_LF    = 8'h0A;
    localparam logic [7:0] ASC_SPACE = 8'h20;
    localparam logic [7:0] ASC_QUEST = 8'h3F;
    localparam logic [7:0] ASC_NUL   = 8'h00;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_EOF  = 2'd1;
    localparam logic [1:0] KIND_INTR = 2'd2;

    localparam int SCTR_QDEPTH = 4;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] kind;
        logic       tab;   // repeat five times
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [7:0] key_ascii(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'h02: ch = "1";
            7'h03: ch = "2";
            7'h04: ch = "3";
            7'h05: ch = "4";
            7'h06: ch = "5";
            7'h07: ch = "6";
            7'h08: ch = "7";
            7'h09: ch = "8";
            7'h0A: ch = "9";
            7'h0B: ch = "0";
            7'h0C: ch = "-";
            7'h0D: ch = "=";
            7'h1E: ch = "a";
            7'h30: ch = "b";
            7'h2E: ch = "c";
            7'h20: ch = "d";
            7'h12: ch = "e";
            7'h21: ch = "f";
            7'h22: ch = "g";
            7'h23: ch = "h";
            7'h17: ch = "i";
            7'h24: ch = "j";
            7'h25: ch = "k";
            7'h26: ch = "l";
            7'h32: ch = "m";
            7'h31: ch = "n";
            7'h18: ch = "o";
            7'h19: ch = "p";
            7'h10: ch = "q";
            7'h13: ch = "r";
            7'h1F: ch = "s";
            7'h14: ch = "t";
            7'h16: ch = "u";
            7'h2F: ch = "v";
            7'h11: ch = "w";
            7'h2D: ch = "x";
            7'h15: ch = "y";
            7'h2C: ch = "z";
            7'h39: ch = " ";
            7'h2B: ch = "|";
            default: ch = ASC_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] digit_shifted(input logic [3:0] d);
        logic [7:0] ch;
        case (d)
            4'd0: ch = ")";
            4'd1: ch = "!";
            4'd2: ch = "@";
            4'd3: ch = "#";
            4'd4: ch = "$";
            4'd5: ch = "%";
            4'd6: ch = "^";
            4'd7: ch = "&";
            4'd8: ch = "*";
            4'd9: ch = "(";
            default: ch = ASC_NUL;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/sctr_front.sv
// Front end: modifier tracking and classification of scan codes into commands.
`default_nettype none
module sctr_front
    import sctr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       acc,
    input  wire logic [7:0] code_in,
    output logic            push,
    output cmd_t            cmd
);

    logic       shift_reg, shift_next;
    logic       ctrl_reg, ctrl_next;
    logic       caps_reg, caps_next;
    logic [6:0] code;
    logic       pressed;
    logic       silent;
    logic [7:0] base;
    logic [7:0] xlat;

    assign code    = code_in[6:0];
    assign pressed = !code_in[7];

    assign silent = (code == KEY_NONE) || (code == KEY_ESC) || (code == KEY_LEFT) ||
                    (code == KEY_RIGHT) || (code == KEY_CTRL) || (code == KEY_CAPS) ||
                    (code == KEY_LSH) || (code == KEY_RSH);

    // Modifier keys are silent, so the registered state is the one in force.
    always_comb
    begin
        base = key_ascii(code);
        if (base == ASC_NUL)
            xlat = ASC_QUEST;
        else if (base >= "a" && base <= "z" && (caps_reg || shift_reg))
            xlat = base - CASE_DIFF;
        else if (base >= "0" && base <= "9" && shift_reg)
            xlat = digit_shifted(4'(base - "0"));
        else
            xlat = base;
    end

    always_comb
    begin
        shift_next = shift_reg;
        ctrl_next  = ctrl_reg;
        caps_next  = caps_reg;
        if (acc)
        begin
            if (code == KEY_LSH || code == KEY_RSH)
                shift_next = pressed;
            else if (code == KEY_CTRL)
                ctrl_next = pressed;
            else if (code == KEY_CAPS && pressed)
                caps_next = !caps_reg;
        end
    end

    always_comb
    begin
        push     = acc && pressed;
        cmd.ch   = xlat;
        cmd.kind = KIND_CHAR;
        cmd.tab  = 1'b0;
        if (ctrl_reg && code == KEY_C)
        begin
            cmd.ch   = ASC_NUL;
            cmd.kind = KIND_INTR;
        end
        else if (ctrl_reg && code == KEY_D)
        begin
            cmd.ch   = ASC_NUL;
            cmd.kind = KIND_EOF;
        end
        else if (code == KEY_BKSP)
            cmd.ch = ASC_BKSP;
        else if (code == KEY_ENTER)
            cmd.ch = ASC_LF;
        else if (code == KEY_TAB)
        begin
            cmd.ch  = ASC_SPACE;
            cmd.tab = 1'b1;
        end
        else if (silent)
            push = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            ctrl_reg  <= 1'b0;
            caps_reg  <= 1'b0;
        end
        else
        begin
            shift_reg <= shift_next;
            ctrl_reg  <= ctrl_next;
            caps_reg  <= caps_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sctr_fifo.sv
// Command queue between the front end and the output sequencer.
`default_nettype none
module sctr_fifo
    import sctr_pkg::*;
#(
    parameter int QDepth = SCTR_QDEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire cmd_t  wr_cmd,
    input  wire logic  pop,
    output cmd_t       rd_cmd,
    output q_stat_t    stat
);

    localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int CntW = $clog2(QDepth + 1);

    cmd_t            mem [QDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign stat.full  = (count_reg == CntW'(QDepth));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_cmd     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sctr_back.sv
// Back end: expands commands into result transfers through an output register.
`default_nettype none
module sctr_back
    import sctr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmd_t       head,
    input  wire q_stat_t    qstat,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);

    logic       valid_reg, valid_next;
    logic [7:0] ch_reg, ch_next;
    logic [1:0] kind_reg, kind_next;
    logic       last_reg, last_next;
    logic [2:0] rem_reg, rem_next;   // results still owed after the one shown
    logic       load;

    assign load = !valid_reg || m_tready;

    always_comb
    begin
        pop        = 1'b0;
        valid_next = valid_reg;
        ch_next    = ch_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        rem_next   = rem_reg;
        if (load)
        begin
            if (rem_reg != '0)
            begin
                // tab burst: same character again
                valid_next = 1'b1;
                rem_next   = rem_reg - 1'b1;
                last_next  = (rem_reg == 3'd1);
            end
            else if (!qstat.empty)
            begin
                pop        = 1'b1;
                valid_next = 1'b1;
                ch_next    = head.ch;
                kind_next  = head.kind;
                rem_next   = head.tab ? TAB_SPACES - 1'b1 : 3'd0;
                last_next  = !head.tab;
            end
            else
                valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = ch_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

FILE: rtl/scancode_to_ascii_translator_core.sv
// Scan code set 1 to ASCII translator: top level.
//
// Input stream s_*: one raw set-1 scan code per transfer, bit 7 marks a release.
// Output stream m_*: one result per transfer; tdata is the character, tuser the
// kind (character, end of file, interrupt), tlast marks the final result of a code.
// Release codes and modifier or other silent keys update state and give nothing.
// m_tvalid rises after a scan code transfer once its command has passed the queue write
// and then the output register.
// Throughput: one scan code per cycle while results are taken each cycle; a tab
// gives five results, all through the single output register.
// A command queue of QDepth entries sits between classification and output, so
// the input keeps flowing while a stalled receiver holds a result.
// When the receiver stalls, the result holds and s_tready drops once the queue fills.
// Reset clears shift, ctrl and caps lock, empties the queue and drops m_tvalid.
`default_nettype none
module scancode_to_ascii_translator_core
    import sctr_pkg::*;
#(
    parameter int QDepth = SCTR_QDEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] scan_code
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // [7:0] char_code
    output logic [1:0]      m_tuser,    // [1:0] kind
    output logic            m_tlast
);

`include "assert_macros.svh"

    logic    s_acc;
    logic    push;
    logic    pop;
    cmd_t    wr_cmd;
    cmd_t    head;
    q_stat_t qstat;

    assign s_tready = !qstat.full;
    assign s_acc    = s_tvalid && s_tready;

    sctr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (s_acc),
        .code_in (s_tdata),
        .push    (push),
        .cmd     (wr_cmd)
    );

    sctr_fifo #(
        .QDepth (QDepth)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .rd_cmd (head),
        .stat   (qstat)
    );

    sctr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .qstat    (qstat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `ASSERT_ALWAYS(a_q_state, !(qstat.full && qstat.empty), "queue both full and empty")
    `ASSERT_IMPLIES(a_rel_quiet, s_acc && s_tdata[7], !push, "release code queued a result")
    `ASSERT_IMPLIES(a_evt_last, m_tvalid && m_tuser != KIND_CHAR, m_tlast,
                    "event result without tlast")
    `ASSERT_NEXT(a_pop_shows, pop, m_tvalid, "popped command not presented")

endmodule
`default_nettype wire
